// File: hw/rtl/segment_intersection_classifier_defines.svh
// ----------------------------------------------------------------------------
// Segment intersection classifier: assertion macros
// Checks are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_DEFINES_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define SIC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sic: assertion failed");
`define SIC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sic: assertion failed");
`else
`define SIC_ASSERT(lbl, prop)
`define SIC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared widths, codes and types of the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIFF_W        = COORD_W + 1;
  localparam int unsigned PROD_W        = 2 * DIFF_W;
  localparam int unsigned DET_W         = PROD_W + 1;
  localparam int unsigned MAG_W         = 65;
  localparam int unsigned MD_W          = COORD_W;
  localparam int unsigned MLO_W         = 33;
  localparam int unsigned MHI_W         = MAG_W - MLO_W;
  localparam int unsigned LIMIT_W       = 63;
  localparam int unsigned QUOT_W        = 33;
  localparam int unsigned DIVR_W        = MAG_W + 1;
  localparam int unsigned DIVD_W        = 99;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSIDE   = 3'd0,
    KIND_OUT_A    = 3'd1,
    KIND_OUT_B    = 3'd2,
    KIND_OUT_BOTH = 3'd3,
    KIND_PARALLEL = 3'd4,
    KIND_COINCIDE = 3'd5
  } kind_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg1_start_x;
    logic signed [COORD_W-1:0] seg1_start_y;
    logic signed [COORD_W-1:0] seg1_end_x;
    logic signed [COORD_W-1:0] seg1_end_y;
    logic signed [COORD_W-1:0] seg2_start_x;
    logic signed [COORD_W-1:0] seg2_start_y;
    logic signed [COORD_W-1:0] seg2_end_x;
    logic signed [COORD_W-1:0] seg2_end_y;
  } seg_t;

  // one classified request waiting for division
  typedef struct packed {
    kind_e                     kind;
    logic [DIVD_W-1:0]         num_a;
    logic [DIVD_W-1:0]         num_b;
    logic [DIVD_W-1:0]         num_x;
    logic [DIVD_W-1:0]         num_y;
    logic [DIVR_W-1:0]         den2;
    logic                      sgn_a;
    logic                      sgn_b;
    logic                      sgn_x;
    logic                      sgn_y;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: hw/rtl/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// Six-stage front: exact determinants, magnitudes, negligible tests,
// classification and division operands.
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  seg_t               seg_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               valid_o,
  output entry_t             entry_o
);

  // stage 1
  logic signed [DIFF_W-1:0]  d1x_q, d1y_q, d2x_q, d2y_q, ox_q, oy_q;
  logic signed [COORD_W-1:0] x1_q1, y1_q1, mx_q1, my_q1;
  logic signed [DIFF_W-1:0]  sumx, sumy;
  logic                      v1_q;

  assign sumx = DIFF_W'(seg_i.seg1_start_x) + DIFF_W'(seg_i.seg1_end_x);
  assign sumy = DIFF_W'(seg_i.seg1_start_y) + DIFF_W'(seg_i.seg1_end_y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1x_q <= DIFF_W'(seg_i.seg1_end_x) - DIFF_W'(seg_i.seg1_start_x);
      d1y_q <= DIFF_W'(seg_i.seg1_end_y) - DIFF_W'(seg_i.seg1_start_y);
      d2x_q <= DIFF_W'(seg_i.seg2_end_x) - DIFF_W'(seg_i.seg2_start_x);
      d2y_q <= DIFF_W'(seg_i.seg2_end_y) - DIFF_W'(seg_i.seg2_start_y);
      ox_q  <= DIFF_W'(seg_i.seg1_start_x) - DIFF_W'(seg_i.seg2_start_x);
      oy_q  <= DIFF_W'(seg_i.seg1_start_y) - DIFF_W'(seg_i.seg2_start_y);
      x1_q1 <= seg_i.seg1_start_x;
      y1_q1 <= seg_i.seg1_start_y;
      mx_q1 <= sumx[DIFF_W-1:1];
      my_q1 <= sumy[DIFF_W-1:1];
    end
  end

  // stage 2: six products
  logic signed [PROD_W-1:0]  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DIFF_W-1:0]  d1x_q2, d1y_q2;
  logic signed [COORD_W-1:0] x1_q2, y1_q2, mx_q2, my_q2;
  logic                      v2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= PROD_W'(d2y_q) * PROD_W'(d1x_q);
      p1_q   <= PROD_W'(d2x_q) * PROD_W'(d1y_q);
      p2_q   <= PROD_W'(d2x_q) * PROD_W'(oy_q);
      p3_q   <= PROD_W'(d2y_q) * PROD_W'(ox_q);
      p4_q   <= PROD_W'(d1x_q) * PROD_W'(oy_q);
      p5_q   <= PROD_W'(d1y_q) * PROD_W'(ox_q);
      d1x_q2 <= d1x_q;
      d1y_q2 <= d1y_q;
      x1_q2  <= x1_q1;
      y1_q2  <= y1_q1;
      mx_q2  <= mx_q1;
      my_q2  <= my_q1;
    end
  end

  // stage 3: determinants
  logic signed [DET_W-1:0]   den_q, na_q, nb_q;
  logic signed [DIFF_W-1:0]  d1x_q3, d1y_q3;
  logic signed [COORD_W-1:0] x1_q3, y1_q3, mx_q3, my_q3;
  logic                      v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= DET_W'(p0_q) - DET_W'(p1_q);
      na_q   <= DET_W'(p2_q) - DET_W'(p3_q);
      nb_q   <= DET_W'(p4_q) - DET_W'(p5_q);
      d1x_q3 <= d1x_q2;
      d1y_q3 <= d1y_q2;
      x1_q3  <= x1_q2;
      y1_q3  <= y1_q2;
      mx_q3  <= mx_q2;
      my_q3  <= my_q2;
    end
  end

  // stage 4: sign and magnitude
  logic [DET_W-1:0]          aden, ana, anb;
  logic [DIFF_W-1:0]         adx, ady;
  logic [MAG_W-1:0]          mden_q4, mna_q4, mnb_q4;
  logic [MD_W-1:0]           mdx_q, mdy_q;
  logic                      sd_q4, sa_q4, sb_q4, sdx_q, sdy_q;
  logic signed [COORD_W-1:0] x1_q4, y1_q4, mx_q4, my_q4;
  logic                      v4_q;

  assign aden = den_q[DET_W-1] ? DET_W'(-den_q) : DET_W'(den_q);
  assign ana  = na_q[DET_W-1]  ? DET_W'(-na_q)  : DET_W'(na_q);
  assign anb  = nb_q[DET_W-1]  ? DET_W'(-nb_q)  : DET_W'(nb_q);
  assign adx  = d1x_q3[DIFF_W-1] ? DIFF_W'(-d1x_q3) : DIFF_W'(d1x_q3);
  assign ady  = d1y_q3[DIFF_W-1] ? DIFF_W'(-d1y_q3) : DIFF_W'(d1y_q3);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mden_q4 <= aden[MAG_W-1:0];
      mna_q4  <= ana[MAG_W-1:0];
      mnb_q4  <= anb[MAG_W-1:0];
      sd_q4   <= den_q[DET_W-1];
      sa_q4   <= na_q[DET_W-1];
      sb_q4   <= nb_q[DET_W-1];
      mdx_q   <= adx[MD_W-1:0];
      mdy_q   <= ady[MD_W-1:0];
      sdx_q   <= d1x_q3[DIFF_W-1];
      sdy_q   <= d1y_q3[DIFF_W-1];
      x1_q4   <= x1_q3;
      y1_q4   <= y1_q3;
      mx_q4   <= mx_q3;
      my_q4   <= my_q3;
    end
  end

  // stage 5: classification and partial products of the point offsets
  logic                      negl_d, negl_a, negl_b, out_a, out_b;
  kind_e                     kind_d, kind_q;
  logic [MLO_W+MD_W-1:0]     pxl_q, pyl_q;
  logic [MHI_W+MD_W-1:0]     pxh_q, pyh_q;
  logic [MAG_W-1:0]          mden_q5, mna_q5, mnb_q5;
  logic                      sgn_a_q, sgn_b_q, sgn_x_q, sgn_y_q;
  logic signed [COORD_W-1:0] bx_q, by_q;
  logic                      v5_q;

  always_comb begin
    negl_d = mden_q4 <= MAG_W'(limit_i);
    negl_a = mna_q4  <= MAG_W'(limit_i);
    negl_b = mnb_q4  <= MAG_W'(limit_i);
    out_a  = ((mna_q4 != '0) && (sa_q4 != sd_q4)) || ((sa_q4 == sd_q4) && (mna_q4 > mden_q4));
    out_b  = ((mnb_q4 != '0) && (sb_q4 != sd_q4)) || ((sb_q4 == sd_q4) && (mnb_q4 > mden_q4));
    if (negl_d && negl_a && negl_b) begin
      kind_d = KIND_COINCIDE;
    end else if (negl_d) begin
      kind_d = KIND_PARALLEL;
    end else begin
      case ({out_b, out_a})
        2'b00:   kind_d = KIND_INSIDE;
        2'b01:   kind_d = KIND_OUT_A;
        2'b10:   kind_d = KIND_OUT_B;
        default: kind_d = KIND_OUT_BOTH;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q  <= kind_d;
      pxl_q   <= (MLO_W+MD_W)'(mna_q4[MLO_W-1:0]) * (MLO_W+MD_W)'(mdx_q);
      pxh_q   <= (MHI_W+MD_W)'(mna_q4[MAG_W-1:MLO_W]) * (MHI_W+MD_W)'(mdx_q);
      pyl_q   <= (MLO_W+MD_W)'(mna_q4[MLO_W-1:0]) * (MLO_W+MD_W)'(mdy_q);
      pyh_q   <= (MHI_W+MD_W)'(mna_q4[MAG_W-1:MLO_W]) * (MHI_W+MD_W)'(mdy_q);
      mden_q5 <= mden_q4;
      mna_q5  <= mna_q4;
      mnb_q5  <= mnb_q4;
      sgn_a_q <= sa_q4 ^ sd_q4;
      sgn_b_q <= sb_q4 ^ sd_q4;
      sgn_x_q <= sa_q4 ^ sdx_q ^ sd_q4;
      sgn_y_q <= sa_q4 ^ sdy_q ^ sd_q4;
      bx_q    <= (kind_d == KIND_COINCIDE) ? mx_q4 : x1_q4;
      by_q    <= (kind_d == KIND_COINCIDE) ? my_q4 : y1_q4;
    end
  end

  // stage 6: dividends 2n + d for round-half-away quotients
  logic [DIVD_W-1:0] nx, ny;
  entry_t            entry_q;
  logic              v6_q;

  assign nx = (DIVD_W'(pxh_q) << MLO_W) + DIVD_W'(pxl_q);
  assign ny = (DIVD_W'(pyh_q) << MLO_W) + DIVD_W'(pyl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q.kind   <= kind_q;
      entry_q.num_a  <= (DIVD_W'(mna_q5) << (FRAC_BITS + 1)) + DIVD_W'(mden_q5);
      entry_q.num_b  <= (DIVD_W'(mnb_q5) << (FRAC_BITS + 1)) + DIVD_W'(mden_q5);
      entry_q.num_x  <= (nx << 1) + DIVD_W'(mden_q5);
      entry_q.num_y  <= (ny << 1) + DIVD_W'(mden_q5);
      entry_q.den2   <= {mden_q5, 1'b0};
      entry_q.sgn_a  <= sgn_a_q;
      entry_q.sgn_b  <= sgn_b_q;
      entry_q.sgn_x  <= sgn_x_q;
      entry_q.sgn_y  <= sgn_y_q;
      entry_q.base_x <= bx_q;
      entry_q.base_y <= by_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign valid_o = v6_q;
  assign entry_o = entry_q;

endmodule

// File: hw/rtl/sic_queue.sv
// ----------------------------------------------------------------------------
// sic_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "segment_intersection_classifier_defines.svh"

module sic_queue import sic_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  entry_t wr_data_i,
  input  logic   rd_en_i,
  output entry_t rd_data_o,
  output qstat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  `SIC_ASSERT(a_no_overflow, wr_en_i |-> !stat_o.full)
  `SIC_ASSERT(a_no_underflow, rd_en_i |-> !stat_o.empty)
  `SIC_ASSERT(a_count_range, cnt_q <= CNT_W'(DEPTH))

endmodule

// File: hw/rtl/sic_div.sv
// ----------------------------------------------------------------------------
// sic_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient does not fit.
// ----------------------------------------------------------------------------
module sic_div import sic_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIVD_W-1:0] num_i,
  input  logic [DIVR_W-1:0] den_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic              ovf_o
);

  localparam int unsigned HI_W = DIVD_W - QUOT_W;

  logic [DIVR_W-1:0] rem_q [QUOT_W];
  logic [QUOT_W-1:0] low_q [QUOT_W];
  logic [DIVR_W-1:0] den_q [QUOT_W];
  logic [QUOT_W-1:0] quo_q [QUOT_W+1];
  logic              ovf_q [QUOT_W+1];
  logic [HI_W-1:0]   hi;

  assign hi = num_i[DIVD_W-1:QUOT_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi[DIVR_W-1:0];
      low_q[0] <= num_i[QUOT_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= hi >= HI_W'(den_i);
    end
  end

  for (genvar i = 1; i <= QUOT_W; i++) begin : g_stage
    logic [DIVR_W:0] trial, diff;
    logic            ge;

    assign trial = {rem_q[i-1], low_q[i-1][QUOT_W-1]};
    assign diff  = trial - {1'b0, den_q[i-1]};
    assign ge    = trial >= {1'b0, den_q[i-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i] <= {quo_q[i-1][QUOT_W-2:0], ge};
        ovf_q[i] <= ovf_q[i-1];
      end
    end

    if (i < QUOT_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
          low_q[i] <= {low_q[i-1][QUOT_W-2:0], 1'b0};
          den_q[i] <= den_q[i-1];
        end
      end
    end
  end

  assign quot_o = quo_q[QUOT_W];
  assign ovf_o  = ovf_q[QUOT_W];

endmodule

// File: hw/rtl/sic_back.sv
// ----------------------------------------------------------------------------
// sic_back
// Back end: four dividers, saturation and an output register with skid.
// ----------------------------------------------------------------------------
module sic_back import sic_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qstat_t                    qstat_i,
  input  entry_t                    head_i,
  output logic                      pop_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output kind_e                     kind_o,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] ratio_a_o,
  output logic signed [COORD_W-1:0] ratio_b_o
);

  localparam int unsigned LAT = QUOT_W + 1;
  localparam int unsigned SUM_W = QUOT_W + 2;

  typedef struct packed {
    kind_e                     kind;
    logic                      sgn_a;
    logic                      sgn_b;
    logic                      sgn_x;
    logic                      sgn_y;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
  } side_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] ra;
    logic signed [COORD_W-1:0] rb;
  } res_t;

  function automatic logic [COORD_W-1:0] sat_ratio(input logic s,
                                                   input logic [QUOT_W-1:0] q,
                                                   input logic ov);
    logic [COORD_W-1:0] r;
    if (ov) begin
      r = s ? SAT_MIN : SAT_MAX;
    end else if (!s) begin
      r = (q > QUOT_W'(SAT_MAX)) ? SAT_MAX : q[COORD_W-1:0];
    end else begin
      r = (q > QUOT_W'(SAT_MIN)) ? SAT_MIN : (~q[COORD_W-1:0]) + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_point(input logic signed [COORD_W-1:0] b,
                                                   input logic s,
                                                   input logic [QUOT_W-1:0] q,
                                                   input logic ov);
    logic signed [SUM_W-1:0] off, sum;
    logic [COORD_W-1:0]      r;
    off = s ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
    sum = SUM_W'(b) + off;
    if (ov) begin
      r = s ? SAT_MIN : SAT_MAX;
    end else if (sum > SUM_W'($signed(SAT_MAX))) begin
      r = SAT_MAX;
    end else if (sum < SUM_W'($signed(SAT_MIN))) begin
      r = SAT_MIN;
    end else begin
      r = sum[COORD_W-1:0];
    end
    return r;
  endfunction

  logic              en;
  logic              v_q [LAT];
  side_t             side_q [LAT];
  logic [QUOT_W-1:0] qa, qb, qx, qy;
  logic              oa, ob, ox, oy;
  res_t              res, out_q, skid_q;
  logic              out_v_q, skid_v_q;
  side_t             tail;

  assign en    = !skid_v_q;
  assign pop_o = en && !qstat_i.empty;

  sic_div u_div_a (.clk_i, .en_i(en), .num_i(head_i.num_a), .den_i(head_i.den2),
                   .quot_o(qa), .ovf_o(oa));
  sic_div u_div_b (.clk_i, .en_i(en), .num_i(head_i.num_b), .den_i(head_i.den2),
                   .quot_o(qb), .ovf_o(ob));
  sic_div u_div_x (.clk_i, .en_i(en), .num_i(head_i.num_x), .den_i(head_i.den2),
                   .quot_o(qx), .ovf_o(ox));
  sic_div u_div_y (.clk_i, .en_i(en), .num_i(head_i.num_y), .den_i(head_i.den2),
                   .quot_o(qy), .ovf_o(oy));

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].kind   <= head_i.kind;
      side_q[0].sgn_a  <= head_i.sgn_a;
      side_q[0].sgn_b  <= head_i.sgn_b;
      side_q[0].sgn_x  <= head_i.sgn_x;
      side_q[0].sgn_y  <= head_i.sgn_y;
      side_q[0].base_x <= head_i.base_x;
      side_q[0].base_y <= head_i.base_y;
      for (int i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= pop_o;
      for (int i = 1; i < LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  assign tail = side_q[LAT-1];

  always_comb begin
    res.kind = tail.kind;
    case (tail.kind)
      KIND_COINCIDE: begin
        res.px = tail.base_x;
        res.py = tail.base_y;
        res.ra = '0;
        res.rb = '0;
      end
      KIND_PARALLEL: begin
        res.px = '0;
        res.py = '0;
        res.ra = '0;
        res.rb = '0;
      end
      default: begin
        res.px = sat_point(tail.base_x, tail.sgn_x, qx, ox);
        res.py = sat_point(tail.base_y, tail.sgn_y, qy, oy);
        res.ra = sat_ratio(tail.sgn_a, qa, oa);
        res.rb = sat_ratio(tail.sgn_b, qb, ob);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (v_q[LAT-1]) begin
        if (!out_v_q || ready_i) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end else if (ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (v_q[LAT-1]) begin
        if (!out_v_q || ready_i) begin
          out_q <= res;
        end else begin
          skid_q <= res;
        end
      end
    end else if (ready_i) begin
      out_q <= skid_q;
    end
  end

  assign valid_o   = out_v_q;
  assign kind_o    = out_q.kind;
  assign point_x_o = out_q.px;
  assign point_y_o = out_q.py;
  assign ratio_a_o = out_q.ra;
  assign ratio_b_o = out_q.rb;

endmodule

// File: hw/rtl/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// segment_intersection_classifier
// Intersection, parameters and classification of two 2D segments in
// signed fixed point.
//
//   port group   dir  contents (lowest bits first)
//   s_axis       in   tdata: seg1 start x/y, seg1 end x/y, seg2 start x/y,
//                     seg2 end x/y, 32 bits each
//   m_axis       out  tdata: point x, point y, ratio a, ratio b; tuser: kind
//   cfg          in   negligible limit, 63 bits
//
// One request per cycle while neither the queue nor the output skid stage stalls
// the flow. Path: six front stages, the queue, a 34-stage divider pipeline, output register.
// The divider pipeline advances whenever the output skid stage is empty.
// Reset clears control state only; the limit register resets to zero.
// ----------------------------------------------------------------------------
module segment_intersection_classifier import sic_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [8*COORD_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // point_x, point_y, ratio_a, ratio_b
  output logic [4*COORD_W-1:0] m_axis_tdata,
  // kind
  output logic [KIND_W-1:0]    m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  logic [LIMIT_W-1:0]        limit_q;
  seg_t                      seg;
  logic                      front_en, front_v;
  entry_t                    front_entry, head;
  qstat_t                    qstat;
  logic                      pop;
  kind_e                     kind;
  logic signed [COORD_W-1:0] px, py, ra, rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign seg.seg1_start_x = s_axis_tdata[0*COORD_W +: COORD_W];
  assign seg.seg1_start_y = s_axis_tdata[1*COORD_W +: COORD_W];
  assign seg.seg1_end_x   = s_axis_tdata[2*COORD_W +: COORD_W];
  assign seg.seg1_end_y   = s_axis_tdata[3*COORD_W +: COORD_W];
  assign seg.seg2_start_x = s_axis_tdata[4*COORD_W +: COORD_W];
  assign seg.seg2_start_y = s_axis_tdata[5*COORD_W +: COORD_W];
  assign seg.seg2_end_x   = s_axis_tdata[6*COORD_W +: COORD_W];
  assign seg.seg2_end_y   = s_axis_tdata[7*COORD_W +: COORD_W];

  assign front_en      = !qstat.full;
  assign s_axis_tready = front_en;

  sic_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .en_i    (front_en),
    .valid_i (s_axis_tvalid),
    .seg_i   (seg),
    .limit_i (limit_q),
    .valid_o (front_v),
    .entry_o (front_entry)
  );

  sic_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .wr_en_i   (front_en && front_v),
    .wr_data_i (front_entry),
    .rd_en_i   (pop),
    .rd_data_o (head),
    .stat_o    (qstat)
  );

  sic_back u_back (
    .clk_i,
    .rst_ni,
    .qstat_i   (qstat),
    .head_i    (head),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .kind_o    (kind),
    .point_x_o (px),
    .point_y_o (py),
    .ratio_a_o (ra),
    .ratio_b_o (rb)
  );

  assign m_axis_tdata = {rb, ra, py, px};
  assign m_axis_tuser = kind;

endmodule

// File: verif/segment_intersection_classifier_test.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier testbench
// Drives segment pairs through the input stream with random gaps, predicts
// kind, point and ratios with exact wide arithmetic and checks every result
// in order, under several negligible limits and random output stalls.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_test;
  import sic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [129:0] wide_t;
  typedef logic [129:0] uwide_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] ra;
    logic [31:0] rb;
  } isect_t;

  localparam wide_t SAT_HI = wide_t'(64'sd2147483647);
  localparam wide_t SAT_LO = -wide_t'(64'sd2147483648);
  localparam int unsigned ONE = 65536;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [8*COORD_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [4*COORD_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  seg_t   pending_segs[$];
  isect_t expected_isects[$];
  logic [LIMIT_W-1:0] limit_r;
  bit     fast_mode;
  int     fail_cnt;
  int     send_gap;
  int     recv_stall;
  int unsigned cycle_cnt;
  seg_t   cur_seg;

  always #10 clk_i = ~clk_i;

  segment_intersection_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic uwide_t mag_of(wide_t v);
    return v < 0 ? uwide_t'(-v) : uwide_t'(v);
  endfunction

  function automatic logic [31:0] sat32(wide_t v);
    if (v > SAT_HI) return SAT_MAX;
    if (v < SAT_LO) return SAT_MIN;
    return v[31:0];
  endfunction

  // nearest, halves away from zero
  function automatic wide_t div_round(wide_t n, wide_t d);
    uwide_t q;
    q = (2 * mag_of(n) + mag_of(d)) / (2 * mag_of(d));
    return ((n < 0) != (d < 0)) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic bit outside(wide_t n, wide_t d);
    if (n != 0 && ((n < 0) != (d < 0))) return 1'b1;
    return mag_of(n) > mag_of(d);
  endfunction

  function automatic isect_t classify_pair(seg_t s, logic [LIMIT_W-1:0] lim);
    wide_t x1, y1, x2, y2, x3, y3, x4, y4;
    wide_t d1x, d1y, d2x, d2y, ox, oy, den, na, nb;
    uwide_t lw;
    bit neg_den, neg_na, neg_nb;
    isect_t r;
    x1 = wide_t'(s.seg1_start_x); y1 = wide_t'(s.seg1_start_y);
    x2 = wide_t'(s.seg1_end_x);   y2 = wide_t'(s.seg1_end_y);
    x3 = wide_t'(s.seg2_start_x); y3 = wide_t'(s.seg2_start_y);
    x4 = wide_t'(s.seg2_end_x);   y4 = wide_t'(s.seg2_end_y);
    d1x = x2 - x1; d1y = y2 - y1; d2x = x4 - x3; d2y = y4 - y3;
    ox = x1 - x3; oy = y1 - y3;
    den = d2y * d1x - d2x * d1y;
    na  = d2x * oy - d2y * ox;
    nb  = d1x * oy - d1y * ox;
    lw = uwide_t'(lim);
    neg_den = mag_of(den) <= lw;
    neg_na  = mag_of(na) <= lw;
    neg_nb  = mag_of(nb) <= lw;
    r.ra = '0; r.rb = '0;
    if (neg_den && neg_na && neg_nb) begin
      r.kind = KIND_COINCIDE;
      r.px = 32'((x1 + x2) >>> 1);
      r.py = 32'((y1 + y2) >>> 1);
    end else if (neg_den) begin
      r.kind = KIND_PARALLEL;
      r.px = '0; r.py = '0;
    end else begin
      r.ra = sat32(div_round(na <<< 16, den));
      r.rb = sat32(div_round(nb <<< 16, den));
      r.px = sat32(x1 + div_round(na * d1x, den));
      r.py = sat32(y1 + div_round(na * d1y, den));
      r.kind = kind_e'({outside(nb, den), outside(na, den)});
    end
    return r;
  endfunction

  function automatic logic [8*COORD_W-1:0] pack_seg(seg_t s);
    return {s.seg2_end_y, s.seg2_end_x, s.seg2_start_y, s.seg2_start_x,
            s.seg1_end_y, s.seg1_end_x, s.seg1_start_y, s.seg1_start_x};
  endfunction

  task automatic add_seg(input logic [31:0] a, b, c, d, e, f, g, h);
    seg_t s;
    s.seg1_start_x = a; s.seg1_start_y = b; s.seg1_end_x = c; s.seg1_end_y = d;
    s.seg2_start_x = e; s.seg2_start_y = f; s.seg2_end_x = g; s.seg2_end_y = h;
    pending_segs.push_back(s);
  endtask

  function automatic logic [31:0] rnd_span(int unsigned bits);
    return $urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1));
  endfunction

  task automatic add_random_seg();
    int unsigned mode;
    int unsigned b;
    logic [31:0] x1, y1, dx, dy, k1, k2;
    mode = $urandom_range(0, 9);
    b = $urandom_range(3, 22);
    x1 = rnd_span(b); y1 = rnd_span(b);
    case (mode)
      0, 1: begin
        add_seg($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      end
      6: begin
        // shifted copy, same direction
        dx = rnd_span(b); dy = rnd_span(b); k1 = rnd_span(b); k2 = rnd_span(b);
        add_seg(x1, y1, x1 + dx, y1 + dy, x1 + k1, y1 + k2, x1 + k1 + 2 * dx,
                y1 + k2 + 2 * dy);
      end
      7: begin
        // on the same line
        b = $urandom_range(2, 14);
        dx = rnd_span(b); dy = rnd_span(b);
        k1 = $urandom_range(0, 6) - 3; k2 = $urandom_range(0, 6) - 3;
        add_seg(x1, y1, x1 + dx, y1 + dy, x1 + k1 * dx, y1 + k1 * dy,
                x1 + k2 * dx, y1 + k2 * dy);
      end
      8: begin
        add_seg(rnd_span(3), rnd_span(3), rnd_span(3), rnd_span(3),
                rnd_span(3), rnd_span(3), rnd_span(3), rnd_span(3));
      end
      9: begin
        add_seg(x1, y1, x1, y1, rnd_span(b), rnd_span(b), rnd_span(b), rnd_span(b));
      end
      default: begin
        add_seg(x1, y1, rnd_span(b), rnd_span(b),
                rnd_span(b), rnd_span(b), rnd_span(b), rnd_span(b));
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_segs.size() != 0 || s_axis_tvalid || expected_isects.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    limit_r = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request side
  always @(posedge clk_i) begin
    bit nv;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_isects.push_back(classify_pair(cur_seg, limit_r));
      if (!s_axis_tvalid || s_axis_tready) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_segs.size() != 0) begin
          cur_seg = pending_segs.pop_front();
          s_axis_tdata <= pack_seg(cur_seg);
          nv = 1'b1;
          send_gap = fast_mode ? 0 : $urandom_range(0, 14);
        end
        s_axis_tvalid <= nv;
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    isect_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_isects.size() == 0) begin
          $error("unexpected result kind %0d", m_axis_tuser);
          fail_cnt++;
        end else begin
          e = expected_isects.pop_front();
          if (m_axis_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[31:0] !== e.px) begin
            $error("point_x: expected %h, got %h", e.px, m_axis_tdata[31:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[63:32] !== e.py) begin
            $error("point_y: expected %h, got %h", e.py, m_axis_tdata[63:32]);
            fail_cnt++;
          end
          if (m_axis_tdata[95:64] !== e.ra) begin
            $error("ratio_a: expected %h, got %h", e.ra, m_axis_tdata[95:64]);
            fail_cnt++;
          end
          if (m_axis_tdata[127:96] !== e.rb) begin
            $error("ratio_b: expected %h, got %h", e.rb, m_axis_tdata[127:96]);
            fail_cnt++;
          end
        end
        recv_stall = fast_mode ? 0 : $urandom_range(0, 14);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits[6];
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    limit_r = '0;
    fast_mode = 1'b0;
    fail_cnt = 0;
    send_gap = 0;
    recv_stall = 0;
    cycle_cnt = 0;
    limits[0] = '0;
    limits[1] = {LIMIT_W{1'b1}};
    limits[2] = 63'd1 << 20;
    limits[3] = 63'd1 << 40;
    limits[4] = LIMIT_W'({$urandom, $urandom});
    limits[5] = 63'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      fast_mode = (ph % 2) == 1;
      if (ph == 0 || ph == 2) begin
        add_seg(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add_seg('0, '0, '0, '0, '0, '0, '0, '0);
        add_seg('1, '1, '1, '1, '1, '1, '1, '1);
        add_seg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        // crossing inside both
        add_seg(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0);
        // outside one, outside two, outside both
        add_seg(0, 0, ONE / 4, ONE / 4, 0, 2 * ONE, 2 * ONE, 0);
        add_seg(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, ONE / 4, 7 * ONE / 4);
        add_seg(0, 0, ONE / 4, ONE / 4, 0, 2 * ONE, ONE / 4, 7 * ONE / 4);
        // endpoint touching, parameter exactly one and zero
        add_seg(0, 0, ONE, 0, ONE, -ONE, ONE, ONE);
        add_seg(0, 0, ONE, 0, 0, -ONE, 0, ONE);
        // parallel, coincident, odd midpoint
        add_seg(0, 0, ONE, ONE, 0, ONE, ONE, 2 * ONE);
        add_seg(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE);
        add_seg(-3, -5, 0, 0, -6, -10, 3, 5);
        add_seg(32'h7fffffff, 32'h7ffffffe, 32'h7fffffff, 32'h7ffffffe,
                1, 1, 1, 1);
        // huge point and ratio saturation
        add_seg(0, 0, 1, 0, 32'h40000000, 32'h80000000, 32'h40000001,
                32'h7fffffff);
        add_seg(0, 0, -1, 0, 32'hc0000000, 32'h80000000, 32'hc0000001,
                32'h7fffffff);
        add_seg(0, 0, 1, 1, 32'h80000000, 32'h80000001, 32'h7fffffff, 32'h7ffffffe);
        // rounding of inexact ratio quotients
        add_seg(0, 0, 3, 0, 1, -1, 1, 1);
        add_seg(0, 0, -3, 0, -1, -1, -1, 1);
      end
      for (int i = 0; i < 225; i++) add_random_seg();
      // hold off until the block has drained
      wait_drained();
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
